// ===== hw/rtl/lcg_bounded_random_macros.svh =====
// Assertion macros shared by the lcg_bounded_random checker.
`ifndef LCG_BOUNDED_RANDOM_MACROS_SVH
`define LCG_BOUNDED_RANDOM_MACROS_SVH

// Clocked assertion, idle while reset is held.
`define LCG_BR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that also checks across reset.
`define LCG_BR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/lcg_br_pkg.sv =====
// Package for lcg_bounded_random: constants, select codes and control types.
package lcg_br_pkg;

    localparam logic [31:0] LCG_MUL   = 32'd214013;
    localparam logic [31:0] LCG_ADD   = 32'd2531011;
    localparam int          LCG_SHIFT = 16;

    // operation codes
    localparam logic [1:0] FUNC_DRAW   = 2'd0;
    localparam logic [1:0] FUNC_UNIQUE = 2'd1;
    localparam logic [1:0] FUNC_LOAD   = 2'd2;

    // divider dividend select
    typedef logic [1:0] t_dvd_sel;
    localparam t_dvd_sel DVD_KEY = 2'd0;
    localparam t_dvd_sel DVD_KM1 = 2'd1;
    localparam t_dvd_sel DVD_ADV = 2'd2;

    // divider divisor select
    typedef logic t_dsr_sel;
    localparam t_dsr_sel DSR_PERIOD = 1'b0;
    localparam t_dsr_sel DSR_MAX    = 1'b1;

    // generator seed select
    typedef logic t_seed_sel;
    localparam t_seed_sel SEED_STATE = 1'b0;
    localparam t_seed_sel SEED_BASE  = 1'b1;

    // result select
    typedef logic [1:0] t_out_sel;
    localparam t_out_sel OUT_ZERO = 2'd0;
    localparam t_out_sel OUT_REM  = 2'd1;
    localparam t_out_sel OUT_BUMP = 2'd2;

    // divider iteration counts
    localparam logic [5:0] DIV_STEPS = 6'd32;
    localparam logic [5:0] MOD_STEPS = 6'd16;

    typedef struct packed {
        logic      load;
        logic      load_state;
        logic      div_start;
        t_dvd_sel  dvd_sel;
        t_dsr_sel  dsr_sel;
        logic      adv;
        t_seed_sel seed_sel;
        logic      adv_to_state;
        logic      save_r;
        logic      out_load;
        t_out_sel  out_sel;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic rem_nz;
    } t_status;

endpackage

// ===== hw/rtl/lcg_br_dp.sv =====
// Datapath: operand registers, generator step, shared restoring divider, result.
module lcg_br_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcg_br_pkg::t_cmd    i_cmd,
    output lcg_br_pkg::t_status o_status,
    input  logic [15:0]         i_max_value,
    input  logic [30:0]         i_period,
    input  logic [31:0]         i_key,
    input  logic [31:0]         i_time_now,
    output logic [15:0]         o_value
);

    logic [15:0] r_max;
    logic [30:0] r_period;
    logic [31:0] r_key;
    logic [31:0] r_time;
    logic [31:0] r_lcg;
    logic [31:0] r_adv;
    logic [31:0] r_num;
    logic [31:0] r_dvd;
    logic [31:0] r_dsr;
    logic [31:0] r_rem;
    logic [5:0]  r_cnt;
    logic [15:0] r_r;
    logic [15:0] r_value;

    logic [31:0] seed_raw;
    logic [31:0] seed;
    logic [31:0] adv_next;
    logic [31:0] dividend;
    logic [31:0] divisor;
    logic [5:0]  steps;
    logic [32:0] trial;
    logic [31:0] rem_next;
    logic [15:0] bumped;
    logic [15:0] value_next;

    always_comb begin
        seed_raw = (i_cmd.seed_sel == lcg_br_pkg::SEED_STATE) ? r_lcg : (r_num - r_rem);
        seed     = (seed_raw == 32'd0) ? r_time : seed_raw;
        adv_next = seed * lcg_br_pkg::LCG_MUL + lcg_br_pkg::LCG_ADD;
    end

    always_comb begin
        unique case (i_cmd.dvd_sel)
            lcg_br_pkg::DVD_KEY: dividend = r_key;
            lcg_br_pkg::DVD_KM1: dividend = r_key - 32'd1;
            lcg_br_pkg::DVD_ADV: dividend = {r_adv[31:lcg_br_pkg::LCG_SHIFT], 16'd0};
            default:             dividend = r_key;
        endcase
        if (i_cmd.dsr_sel == lcg_br_pkg::DSR_PERIOD) begin
            divisor = {1'b0, r_period};
        end else begin
            divisor = {15'd0, {1'b0, r_max} + 17'd1};
        end
        // top half of the draw word only needs its 16 bits shifted through
        steps = (i_cmd.dvd_sel == lcg_br_pkg::DVD_ADV) ? lcg_br_pkg::MOD_STEPS
                                                       : lcg_br_pkg::DIV_STEPS;
    end

    always_comb begin
        trial = {r_rem, r_dvd[31]};
        if (trial >= {1'b0, r_dsr}) begin
            rem_next = 32'(trial - {1'b0, r_dsr});
        end else begin
            rem_next = trial[31:0];
        end
    end

    always_comb begin
        bumped = (r_r == r_max) ? 16'd0 : (r_r + 16'd1);
        unique case (i_cmd.out_sel)
            lcg_br_pkg::OUT_ZERO: value_next = 16'd0;
            lcg_br_pkg::OUT_REM:  value_next = r_rem[15:0];
            lcg_br_pkg::OUT_BUMP: value_next = (r_rem[15:0] == r_r) ? bumped : r_r;
            default:              value_next = 16'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg <= 32'd0;
            r_cnt <= 6'd0;
        end else begin
            if (i_cmd.load_state) begin
                r_lcg <= i_key;
            end else if (i_cmd.adv && i_cmd.adv_to_state) begin
                r_lcg <= adv_next;
            end
            if (i_cmd.div_start) begin
                r_cnt <= steps;
            end else if (r_cnt != 6'd0) begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_max    <= i_max_value;
            r_period <= i_period;
            r_key    <= i_key;
            r_time   <= i_time_now;
        end
        if (i_cmd.adv) begin
            r_adv <= adv_next;
        end
        if (i_cmd.div_start) begin
            r_num <= dividend;
            r_dvd <= dividend;
            r_dsr <= divisor;
            r_rem <= 32'd0;
        end else if (r_cnt != 6'd0) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= rem_next;
        end
        if (i_cmd.save_r) begin
            r_r <= r_rem[15:0];
        end
        if (i_cmd.out_load) begin
            r_value <= value_next;
        end
    end

    assign o_status.div_busy = (r_cnt != 6'd0);
    assign o_status.rem_nz   = (r_rem != 32'd0);
    assign o_value           = r_value;

endmodule

// ===== hw/rtl/lcg_br_ctrl.sv =====
// Controller: sequences draw, unique draw and load over the shared datapath.
module lcg_br_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_func,
    output logic                o_valid,
    input  logic                i_ready,
    input  lcg_br_pkg::t_status i_status,
    output lcg_br_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ADV0 = 4'd1;
    localparam logic [3:0] S_MOD0 = 4'd2;
    localparam logic [3:0] S_DIVK = 4'd3;
    localparam logic [3:0] S_ADV1 = 4'd4;
    localparam logic [3:0] S_MOD1 = 4'd5;
    localparam logic [3:0] S_DIVP = 4'd6;
    localparam logic [3:0] S_ADV2 = 4'd7;
    localparam logic [3:0] S_MOD2 = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0]           r_state, n_state;
    logic                 r_started, n_started;
    logic                 r_bound, n_bound;
    logic                 r_valid, n_valid;
    lcg_br_pkg::t_out_sel r_out_sel, n_out_sel;

    logic div_state;
    logic div_done;

    always_comb begin
        div_state = (r_state == S_MOD0) || (r_state == S_DIVK) || (r_state == S_MOD1) ||
                    (r_state == S_DIVP) || (r_state == S_MOD2);
        div_done  = r_started && !i_status.div_busy;
    end

    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        n_bound   = r_bound;
        n_out_sel = r_out_sel;
        n_valid   = (r_valid && i_ready) ? 1'b0 : r_valid;
        o_cmd     = '0;
        o_cmd.out_sel = r_out_sel;

        // each division state launches the divider once, then waits it out
        if (div_state) begin
            if (!r_started) begin
                o_cmd.div_start = 1'b1;
                n_started       = 1'b1;
            end else if (!i_status.div_busy) begin
                n_started = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_func)
                        lcg_br_pkg::FUNC_DRAW:   n_state = S_ADV0;
                        lcg_br_pkg::FUNC_UNIQUE: n_state = S_DIVK;
                        lcg_br_pkg::FUNC_LOAD: begin
                            o_cmd.load_state = 1'b1;
                            n_out_sel        = lcg_br_pkg::OUT_ZERO;
                            n_state          = S_FIN;
                        end
                        default: begin
                            n_out_sel = lcg_br_pkg::OUT_ZERO;
                            n_state   = S_FIN;
                        end
                    endcase
                end
            end
            S_ADV0: begin
                o_cmd.adv          = 1'b1;
                o_cmd.seed_sel     = lcg_br_pkg::SEED_STATE;
                o_cmd.adv_to_state = 1'b1;
                n_state            = S_MOD0;
            end
            S_MOD0: begin
                o_cmd.dvd_sel = lcg_br_pkg::DVD_ADV;
                o_cmd.dsr_sel = lcg_br_pkg::DSR_MAX;
                if (div_done) begin
                    n_out_sel = lcg_br_pkg::OUT_REM;
                    n_state   = S_FIN;
                end
            end
            S_DIVK: begin
                o_cmd.dvd_sel = lcg_br_pkg::DVD_KEY;
                o_cmd.dsr_sel = lcg_br_pkg::DSR_PERIOD;
                if (div_done) begin
                    n_state = S_ADV1;
                end
            end
            S_ADV1: begin
                o_cmd.adv      = 1'b1;
                o_cmd.seed_sel = lcg_br_pkg::SEED_BASE;
                // zero remainder: key sits on a period boundary
                n_bound        = !i_status.rem_nz;
                n_state        = S_MOD1;
            end
            S_MOD1: begin
                o_cmd.dvd_sel = lcg_br_pkg::DVD_ADV;
                o_cmd.dsr_sel = lcg_br_pkg::DSR_MAX;
                if (div_done) begin
                    o_cmd.save_r = 1'b1;
                    if (r_bound) begin
                        n_state = S_DIVP;
                    end else begin
                        n_out_sel = lcg_br_pkg::OUT_REM;
                        n_state   = S_FIN;
                    end
                end
            end
            S_DIVP: begin
                o_cmd.dvd_sel = lcg_br_pkg::DVD_KM1;
                o_cmd.dsr_sel = lcg_br_pkg::DSR_PERIOD;
                if (div_done) begin
                    n_state = S_ADV2;
                end
            end
            S_ADV2: begin
                o_cmd.adv      = 1'b1;
                o_cmd.seed_sel = lcg_br_pkg::SEED_BASE;
                n_state        = S_MOD2;
            end
            S_MOD2: begin
                o_cmd.dvd_sel = lcg_br_pkg::DVD_ADV;
                o_cmd.dsr_sel = lcg_br_pkg::DSR_MAX;
                if (div_done) begin
                    n_out_sel = lcg_br_pkg::OUT_BUMP;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            r_bound   <= 1'b0;
            r_valid   <= 1'b0;
            r_out_sel <= lcg_br_pkg::OUT_ZERO;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_bound   <= n_bound;
            r_valid   <= n_valid;
            r_out_sel <= n_out_sel;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== hw/rtl/lcg_bounded_random.sv =====
// Top level of lcg_bounded_random: bounded draws from a 32-bit LCG.
//
// Input channel (i_valid/o_ready) takes one transaction: i_func selects a
// sequential draw, a period-unique draw or a state load; the other fields
// are its operands. Output channel (o_valid/i_ready) returns one o_value
// per input transaction, in order.
// One transaction is in work at a time; o_ready is high only while idle.
// A finished value sits in the output register, so the next transaction
// is taken while it waits; that one finishes only once the old value left.
// Draws are computed on the shared one-bit-per-cycle restoring divider
// (32 steps for a period remainder, 16 for the bound); a load or unused
// code uses no division, and a unique draw on a period boundary needs
// two more divisions than one off a boundary.
// Reset clears the generator state to zero and empties the output;
// while i_ready is low the output value holds and work stops at the end.
module lcg_bounded_random (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_max_value,
    input  logic [30:0] i_period,
    input  logic [31:0] i_key,
    input  logic [31:0] i_time_now,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_value
);

    lcg_br_pkg::t_cmd    cmd;
    lcg_br_pkg::t_status status;

    lcg_br_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_max_value (i_max_value),
        .i_period    (i_period),
        .i_key       (i_key),
        .i_time_now  (i_time_now),
        .o_value     (o_value)
    );

    lcg_br_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_func   (i_func),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

endmodule

// ===== hw/rtl/lcg_br_chk.sv =====
// Port-level assertion checker for lcg_bounded_random, with its bind.
`include "lcg_bounded_random_macros.svh"

module lcg_br_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_value
);

    `LCG_BR_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_value), "held out")
    `LCG_BR_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_valid, "output valid after reset")
    `LCG_BR_ASSERT(a_one_busy, i_valid && o_ready |=> !o_ready, "second transaction taken")
    `LCG_BR_ASSERT(a_rise_busy, $rose(o_valid) |-> $past(!o_ready), "result with no work")

endmodule

bind lcg_bounded_random lcg_br_chk u_chk (.*);
